// File: hdl/icmp_echo_pkg.sv
// package: payload types, verdict codes and checksum helper for the icmp echo responder
package icmp_echo_pkg;

   // message byte counter width and minimum legal message length
   localparam int COUNT_WIDTH = 16;
   localparam int MIN_LENGTH = 8;

   // csr port geometry
   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 1;

   // csr register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RX_CHECK_OFFLOAD = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TX_SUM_OFFLOAD = 1'd1;

   // verdict codes
   localparam logic [1:0] VERDICT_ECHO_REPLY = 2'd0;
   localparam logic [1:0] VERDICT_TOO_SHORT = 2'd1;
   localparam logic [1:0] VERDICT_SUM_FAILED = 2'd2;
   localparam logic [1:0] VERDICT_UNSUPPORTED = 2'd3;

   // icmp header values
   localparam logic [7:0] ECHO_REQUEST_TYPE = 8'd8;
   localparam logic [7:0] ECHO_CODE = 8'd0;

   typedef struct packed {
      logic [7:0] msg_byte;
      logic       last_byte;
      logic       hw_sum_bad;
      logic       hw_sum_good;
   } req_type;

   typedef struct packed {
      logic [1:0]  verdict;
      logic [15:0] reply_sum;
      logic        offload_request;
   } rsp_type;

   // one's-complement 16-bit add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] word);
      logic [16:0] s;
      s = {1'b0, acc} + {1'b0, word};
      return s[15:0] + {15'd0, s[16]};
   endfunction

endpackage

// File: hdl/icmp_echo_responder.sv
// top level: streaming icmp echo request checker and reply checksum generator
//
// Takes one ICMP message byte per cycle on the req channel and, on the byte
// marked last, delivers one verdict on the rsp channel in the next cycle: echo
// reply, too short, checksum failed or unsupported type/code. A new byte is
// accepted every cycle; the running one's-complement sums advance by one word
// add per byte pair, and the result sits in an output register so the next
// message streams in while a verdict waits to be taken (req_ready drops only
// while that register is full and rsp_ready is low). For an echo reply the
// reply checksum covers the message with type, code and checksum zeroed; with
// tx_sum_offload set it is left zero and offload_request is raised. With
// rx_check_offload set, the hardware checksum flags on the last byte take
// precedence over the software sum (bad wins over good). Write the CSRs only
// while no message is in flight.
module icmp_echo_responder (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  icmp_echo_pkg::req_type                      req_data,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output icmp_echo_pkg::rsp_type                      rsp_data,
   input  logic                                        csr_wr_en,
   input  logic [icmp_echo_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [icmp_echo_pkg::CSR_DATA_WIDTH-1:0]    csr_wr_data
);
   import icmp_echo_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] MIN_COUNT = COUNT_WIDTH'(MIN_LENGTH);
   localparam logic [COUNT_WIDTH-1:0] POS_CODE = COUNT_WIDTH'(1);
   localparam logic [COUNT_WIDTH-1:0] POS_BODY = COUNT_WIDTH'(4);
   localparam logic [COUNT_WIDTH-1:0] POS_BODY_LOW = COUNT_WIDTH'(5);

   logic                   rx_check_offload_ff;
   logic                   tx_sum_offload_ff;
   logic [15:0]            total_sum_ff, total_sum_in;
   logic [15:0]            body_sum_ff, body_sum_in;
   logic [COUNT_WIDTH-1:0] byte_count_ff, byte_count_in;
   logic [7:0]             high_half_ff, high_half_in;
   logic [7:0]             type_byte_ff, type_byte_in;
   logic [7:0]             code_byte_ff, code_byte_in;
   logic                   odd_phase_ff, odd_phase_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   logic                   req_xfer;
   logic                   rsp_xfer;
   logic [COUNT_WIDTH-1:0] new_count;
   logic [15:0]            word;
   logic                   add_word;
   logic                   add_body;
   logic [15:0]            total_next;
   logic [15:0]            body_next;
   logic                   sum_ok;
   rsp_type                result;

   // handshakes: output register frees up when its result is taken
   assign rsp_xfer  = rsp_valid_ff & rsp_ready;
   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_xfer  = req_valid & req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         rx_check_offload_ff <= 1'b0;
         tx_sum_offload_ff   <= 1'b0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_RX_CHECK_OFFLOAD: rx_check_offload_ff <= csr_wr_data[0];
            CSR_TX_SUM_OFFLOAD:   tx_sum_offload_ff   <= csr_wr_data[0];
            default: ;
         endcase
      end
   end

   // word forming and running sums for the byte in transfer
   always_comb begin
      new_count  = (byte_count_ff == COUNT_MAX) ? COUNT_MAX : byte_count_ff + 1'b1;
      add_word   = odd_phase_ff | req_data.last_byte;
      word       = odd_phase_ff ? {high_half_ff, req_data.msg_byte}
                                : {req_data.msg_byte, 8'h00};
      add_body   = odd_phase_ff ? (byte_count_ff >= POS_BODY_LOW)
                                : (byte_count_ff >= POS_BODY);
      total_next = add_word ? oc_add(total_sum_ff, word) : total_sum_ff;
      body_next  = (add_word && add_body) ? oc_add(body_sum_ff, word) : body_sum_ff;
      type_byte_in = (byte_count_ff == '0) ? req_data.msg_byte : type_byte_ff;
      code_byte_in = (byte_count_ff == POS_CODE) ? req_data.msg_byte : code_byte_ff;
   end

   // verdict for a message ending with this byte
   always_comb begin
      priority if (rx_check_offload_ff && req_data.hw_sum_bad) begin
         sum_ok = 1'b0;
      end else if (rx_check_offload_ff && req_data.hw_sum_good) begin
         sum_ok = 1'b1;
      end else begin
         sum_ok = (total_next == 16'hFFFF);
      end

      result.reply_sum       = '0;
      result.offload_request = 1'b0;
      priority if (new_count < MIN_COUNT) begin
         result.verdict = VERDICT_TOO_SHORT;
      end else if (!sum_ok) begin
         result.verdict = VERDICT_SUM_FAILED;
      end else if (type_byte_in != ECHO_REQUEST_TYPE || code_byte_in != ECHO_CODE) begin
         result.verdict = VERDICT_UNSUPPORTED;
      end else begin
         result.verdict = VERDICT_ECHO_REPLY;
         if (tx_sum_offload_ff) begin
            result.offload_request = 1'b1;
         end else begin
            result.reply_sum = ~body_next;
         end
      end
   end

   // next message state: cleared after the last byte
   always_comb begin
      total_sum_in  = total_sum_ff;
      body_sum_in   = body_sum_ff;
      byte_count_in = byte_count_ff;
      high_half_in  = high_half_ff;
      odd_phase_in  = odd_phase_ff;
      if (req_xfer) begin
         if (req_data.last_byte) begin
            total_sum_in  = '0;
            body_sum_in   = '0;
            byte_count_in = '0;
            high_half_in  = '0;
            odd_phase_in  = 1'b0;
         end else begin
            total_sum_in  = total_next;
            body_sum_in   = body_next;
            byte_count_in = new_count;
            high_half_in  = odd_phase_ff ? high_half_ff : req_data.msg_byte;
            odd_phase_in  = ~odd_phase_ff;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff & ~rsp_xfer;
      rsp_data_in  = rsp_data_ff;
      if (req_xfer && req_data.last_byte) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   // message state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         total_sum_ff  <= '0;
         body_sum_ff   <= '0;
         byte_count_ff <= '0;
         high_half_ff  <= '0;
         type_byte_ff  <= '0;
         code_byte_ff  <= '0;
         odd_phase_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         total_sum_ff  <= total_sum_in;
         body_sum_ff   <= body_sum_in;
         byte_count_ff <= byte_count_in;
         high_half_ff  <= high_half_in;
         odd_phase_ff  <= odd_phase_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (req_xfer) begin
            type_byte_ff <= req_data.last_byte ? 8'h00 : type_byte_in;
            code_byte_ff <= req_data.last_byte ? 8'h00 : code_byte_in;
         end
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   // only an echo reply carries a checksum or an offload request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.verdict != VERDICT_ECHO_REPLY |->
         rsp_data_ff.reply_sum == '0 && !rsp_data_ff.offload_request)
      else $error("non-reply verdict carries checksum or offload");

   // offloaded reply leaves checksum zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.offload_request |-> rsp_data_ff.reply_sum == '0)
      else $error("offload request with nonzero checksum");

   // a last-byte transfer yields a result and clears message state
   assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_data.last_byte |=>
         rsp_valid_ff && byte_count_ff == '0 && !odd_phase_ff && total_sum_ff == '0)
      else $error("message end did not produce result or clear state");

   // a middle byte never produces a result on its own
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff && !(req_xfer && req_data.last_byte) |=> !rsp_valid_ff)
      else $error("result appeared without a last byte");
`endif

endmodule
